>>> rtl/mexu_pkg.sv
package mexu_pkg;

  // Default lane layout: eight variables of eight-bit exponents.
  localparam int unsigned NUM_VARS_DEF = 8;
  localparam int unsigned EXP_BITS_DEF = 8;

  // Fixed field widths of the request and result words.
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned CODE_W   = 4;
  localparam int unsigned VALUE_W  = 8;
  localparam int unsigned DEG_W    = 11;

  typedef enum logic [REQ_W-1:0] {
    REQ_BUILD     = 3'd0,
    REQ_MULTIPLY  = 3'd1,
    REQ_INTEGRATE = 3'd2,
    REQ_DIFF      = 3'd3,
    REQ_SUBST     = 3'd4
  } req_e;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [WORD_W-1:0]  exponents;
    logic [WORD_W-1:0]  operand_exponents;
    logic [CODE_W-1:0]  var_code;
    logic [VALUE_W-1:0] exp_value;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0]  result_exponents;
    logic [DEG_W-1:0]   total_degree;
    logic [CODE_W-1:0]  lowest_var;
    logic [CODE_W-1:0]  highest_var;
    logic [VALUE_W-1:0] returned_value;
    logic               invalid_code;
    logic               overflow;
  } res_t;

endpackage

>>> rtl/monomial_exponent_unit_top.sv
// A word accepted into the input register passes through the lane arithmetic into the result
// register and is then on res_o with done_o high, where the receiver takes it.
// Throughput: one word per cycle; busy_o is always low, so start_i may be held high every cycle.
// The result is shown for exactly one cycle; the receiver cannot stall, so nothing backs up.
// Reset (rst_ni, asynchronous, active low) clears the two stage valid flags; data registers
// are not reset, and no result is issued until a word has been accepted after reset.
module monomial_exponent_unit_top #(
  parameter int unsigned NUM_VARS = mexu_pkg::NUM_VARS_DEF,
  parameter int unsigned EXP_BITS = mexu_pkg::EXP_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  mexu_pkg::req_t  req_i,
  output logic            busy_o,
  output logic            done_o,
  output mexu_pkg::res_t  res_o
);

  // Width of a lane index; a single lane still needs one bit to address it.
  localparam int unsigned IdxW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

  // All-ones lane value, and the same value seen at the width of the build exponent.
  localparam logic [EXP_BITS-1:0] LaneMax = {EXP_BITS{1'b1}};
  localparam logic [mexu_pkg::VALUE_W-1:0] LaneMaxV =
    mexu_pkg::VALUE_W'((1 << EXP_BITS) - 1);
  localparam logic [mexu_pkg::CODE_W-1:0] LastCode = mexu_pkg::CODE_W'(NUM_VARS);

  // The unit takes a new word every cycle, so it is never busy.
  assign busy_o = 1'b0;

  // ---------------------------------------------------------------------------
  // Input register. The valid flag is control state and is reset; the captured
  // request is payload and simply loads whenever a word is accepted.
  // ---------------------------------------------------------------------------
  logic           in_vld_q;
  mexu_pkg::req_t in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      in_q <= req_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Lane arithmetic. The packed words are split into lanes; bits above the
  // last lane are ignored on the way in and driven to zero on the way out.
  // ---------------------------------------------------------------------------
  logic [NUM_VARS-1:0][EXP_BITS-1:0] lane_a;
  logic [NUM_VARS-1:0][EXP_BITS-1:0] lane_b;
  logic [NUM_VARS-1:0][EXP_BITS-1:0] lane_r;
  logic                              code_ok;
  logic [IdxW-1:0]                   idx;
  logic [EXP_BITS-1:0]               sel_e;
  logic [EXP_BITS:0]                 lane_sum;
  logic [mexu_pkg::VALUE_W-1:0]      ret;
  logic                              inval;
  logic                              ovf;

  always_comb begin
    for (int i = 0; i < NUM_VARS; i++) begin
      lane_a[i] = in_q.exponents[i*EXP_BITS +: EXP_BITS];
      lane_b[i] = in_q.operand_exponents[i*EXP_BITS +: EXP_BITS];
    end

    // Variables are numbered from one; code zero and codes past the last lane are invalid.
    code_ok = (in_q.var_code != '0) && (in_q.var_code <= LastCode);
    idx     = code_ok ? IdxW'(in_q.var_code - 1'b1) : '0;
    sel_e   = lane_a[idx];

    lane_r   = lane_a;
    lane_sum = '0;
    ret      = '0;
    inval    = 1'b0;
    ovf      = 1'b0;

    case (in_q.req_type)
      mexu_pkg::REQ_BUILD: begin
        lane_r = '0;
        if (!code_ok) begin
          inval = 1'b1;
        end else if (in_q.exp_value != '0) begin
          // A build exponent too large for the lane is clipped to the lane maximum.
          if (in_q.exp_value > LaneMaxV) begin
            lane_r[idx] = LaneMax;
            ovf         = 1'b1;
          end else begin
            lane_r[idx] = EXP_BITS'(in_q.exp_value);
          end
        end
      end
      mexu_pkg::REQ_MULTIPLY: begin
        // Each lane adds on its own and saturates, so no carry crosses into a neighbour.
        for (int i = 0; i < NUM_VARS; i++) begin
          lane_sum = {1'b0, lane_a[i]} + {1'b0, lane_b[i]};
          if (lane_sum[EXP_BITS]) begin
            lane_r[i] = LaneMax;
            ovf       = 1'b1;
          end else begin
            lane_r[i] = lane_sum[EXP_BITS-1:0];
          end
        end
      end
      mexu_pkg::REQ_INTEGRATE,
      mexu_pkg::REQ_DIFF,
      mexu_pkg::REQ_SUBST: begin
        if (!code_ok) begin
          // The monomial passes through and the offending code is handed back.
          inval = 1'b1;
          ret   = mexu_pkg::VALUE_W'(in_q.var_code);
        end else if (in_q.req_type == mexu_pkg::REQ_INTEGRATE) begin
          if (sel_e == LaneMax) begin
            ovf = 1'b1;
            ret = mexu_pkg::VALUE_W'(sel_e);
          end else begin
            lane_r[idx] = sel_e + 1'b1;
            ret         = mexu_pkg::VALUE_W'(sel_e + 1'b1);
          end
        end else if (in_q.req_type == mexu_pkg::REQ_DIFF) begin
          // Differentiating by a variable that is absent gives the zero monomial.
          ret = mexu_pkg::VALUE_W'(sel_e);
          if (sel_e == '0) begin
            lane_r = '0;
          end else begin
            lane_r[idx] = sel_e - 1'b1;
          end
        end else begin
          ret         = mexu_pkg::VALUE_W'(sel_e);
          lane_r[idx] = '0;
        end
      end
      default: begin
        // Unused request codes leave the monomial untouched and report nothing.
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Summary of the result: total degree and the lowest and highest variables
  // that are present.
  // ---------------------------------------------------------------------------
  mexu_pkg::res_t res_d;

  always_comb begin
    res_d = '0;
    for (int i = 0; i < NUM_VARS; i++) begin
      res_d.result_exponents[i*EXP_BITS +: EXP_BITS] = lane_r[i];
      res_d.total_degree = res_d.total_degree + mexu_pkg::DEG_W'(lane_r[i]);
      if (lane_r[i] != '0) begin
        res_d.highest_var = mexu_pkg::CODE_W'(i + 1);
      end
    end
    for (int i = NUM_VARS - 1; i >= 0; i--) begin
      if (lane_r[i] != '0) begin
        res_d.lowest_var = mexu_pkg::CODE_W'(i + 1);
      end
    end
    res_d.returned_value = ret;
    res_d.invalid_code   = inval;
    res_d.overflow       = ovf;
  end

  // ---------------------------------------------------------------------------
  // Result register. done_o marks the single cycle in which res_o is valid.
  // ---------------------------------------------------------------------------
  logic           done_q;
  mexu_pkg::res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> verif/tb_top.sv
module tb_top;
  import mexu_pkg::*;

  // The lane layout follows the package defaults, which is what the block is built with here.
  localparam int unsigned LANES          = NUM_VARS_DEF;
  localparam int unsigned LANE_BITS      = EXP_BITS_DEF;
  localparam int unsigned LANE_MAX       = (1 << LANE_BITS) - 1;
  // Edges from the acceptance of a word to the sight of its result.
  localparam int unsigned RESULT_LATENCY = 2;
  localparam int unsigned RANDOM_WORDS   = 400;
  localparam int unsigned MAX_REPORTS    = 10;
  // Roughly 420 words, some with short random pauses in front of them, fit well within the
  // limit, which leaves a very wide margin on top of what they need.
  localparam int unsigned CYCLE_LIMIT    = 200000;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  req_t req_i;
  logic busy_o;
  logic done_o;
  res_t res_o;

  // Predicted results, oldest at the front, waiting for the block to produce them.
  res_t        pending_results[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  // When this is low the sender never pauses between words.
  logic        gaps_enabled;

  monomial_exponent_unit_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Works out what the block should return for one request word. Every lane saturates at its
  // maximum; an invalid variable code leaves the monomial untouched for integrate, differentiate
  // and substitute, and request types beyond substitute do nothing at all.
  function automatic res_t predict_monomial(req_t w);
    res_t        p;
    int unsigned a [LANES];
    int unsigned b [LANES];
    int unsigned r [LANES];
    int unsigned e;
    int unsigned sum;
    int unsigned idx;
    int unsigned lo;
    int unsigned hi;
    logic        valid;
    p   = '0;
    sum = 0;
    lo  = 0;
    hi  = 0;
    for (int i = 0; i < LANES; i++) begin
      a[i] = w.exponents[i*LANE_BITS +: LANE_BITS];
      b[i] = w.operand_exponents[i*LANE_BITS +: LANE_BITS];
      r[i] = a[i];
    end
    valid = (w.var_code >= 1) && (w.var_code <= LANES);
    idx   = valid ? w.var_code - 1 : 0;
    case (w.req_type)
      REQ_BUILD: begin
        for (int i = 0; i < LANES; i++) r[i] = 0;
        if (!valid) begin
          p.invalid_code = 1'b1;
        end else if (w.exp_value != 0) begin
          e = w.exp_value;
          if (e > LANE_MAX) begin
            e          = LANE_MAX;
            p.overflow = 1'b1;
          end
          r[idx] = e;
        end
      end
      REQ_MULTIPLY: begin
        for (int i = 0; i < LANES; i++) begin
          e = a[i] + b[i];
          if (e > LANE_MAX) begin
            e          = LANE_MAX;
            p.overflow = 1'b1;
          end
          r[i] = e;
        end
      end
      REQ_INTEGRATE, REQ_DIFF, REQ_SUBST: begin
        if (!valid) begin
          p.invalid_code   = 1'b1;
          p.returned_value = VALUE_W'(w.var_code);
        end else begin
          e = a[idx];
          case (w.req_type)
            REQ_INTEGRATE: begin
              if (e >= LANE_MAX) p.overflow = 1'b1;
              else e++;
              r[idx]           = e;
              p.returned_value = VALUE_W'(e);
            end
            REQ_DIFF: begin
              p.returned_value = VALUE_W'(e);
              if (e == 0) begin
                for (int i = 0; i < LANES; i++) r[i] = 0;
              end else begin
                r[idx] = e - 1;
              end
            end
            default: begin
              p.returned_value = VALUE_W'(e);
              r[idx]           = 0;
            end
          endcase
        end
      end
      default: ;
    endcase
    for (int i = 0; i < LANES; i++) begin
      p.result_exponents[i*LANE_BITS +: LANE_BITS] = LANE_BITS'(r[i]);
      sum += r[i];
      if (r[i] != 0) begin
        if (lo == 0) lo = i + 1;
        hi = i + 1;
      end
    end
    p.total_degree = DEG_W'(sum);
    p.lowest_var   = CODE_W'(lo);
    p.highest_var  = CODE_W'(hi);
    return p;
  endfunction

  function automatic req_t make_request(logic [REQ_W-1:0] op, logic [WORD_W-1:0] exps,
                                        logic [WORD_W-1:0] operand, logic [CODE_W-1:0] code,
                                        logic [VALUE_W-1:0] value);
    req_t w;
    w.req_type          = op;
    w.exponents         = exps;
    w.operand_exponents = operand;
    w.var_code          = code;
    w.exp_value         = value;
    return w;
  endfunction

  // A monomial whose lanes favour the interesting values: empty, full, one below full, one,
  // small enough that a product cannot saturate, or anything at all.
  function automatic logic [WORD_W-1:0] shaped_monomial();
    logic [WORD_W-1:0] m;
    m = '0;
    for (int i = 0; i < LANES; i++) begin
      case ($urandom_range(6))
        0:       m[i*LANE_BITS +: LANE_BITS] = '0;
        1:       m[i*LANE_BITS +: LANE_BITS] = LANE_BITS'(LANE_MAX);
        2:       m[i*LANE_BITS +: LANE_BITS] = LANE_BITS'(LANE_MAX - 1);
        3:       m[i*LANE_BITS +: LANE_BITS] = LANE_BITS'(1);
        4:       m[i*LANE_BITS +: LANE_BITS] = LANE_BITS'($urandom_range(LANE_MAX / 2));
        default: m[i*LANE_BITS +: LANE_BITS] = LANE_BITS'($urandom);
      endcase
    end
    return m;
  endfunction

  function automatic req_t random_request();
    req_t w;
    // Mostly real operations with valid codes; the rest exercises unused types and bad codes.
    if ($urandom_range(99) < 90) w.req_type = REQ_W'($urandom_range(int'(REQ_SUBST)));
    else w.req_type = REQ_W'($urandom_range((1 << REQ_W) - 1));
    w.exponents         = ($urandom_range(3) == 0) ? {$urandom, $urandom} : shaped_monomial();
    w.operand_exponents = ($urandom_range(3) == 0) ? {$urandom, $urandom} : shaped_monomial();
    if ($urandom_range(9) == 0) w.var_code = CODE_W'($urandom_range((1 << CODE_W) - 1));
    else w.var_code = CODE_W'($urandom_range(LANES, 1));
    w.exp_value = ($urandom_range(7) == 0) ? '0 : VALUE_W'($urandom);
    return w;
  endfunction

  // Offers one word at the falling edge, sometimes after a short pause, and keeps it on the
  // bus until a rising edge sees busy_o low. The prediction is queued at that edge.
  task automatic send_word(req_t w);
    @(negedge clk_i);
    while (gaps_enabled && $urandom_range(99) < 8) begin
      start_i <= 1'b0;
      req_i   <= random_request();
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= w;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_results.push_back(predict_monomial(w));
  endtask

  task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("tb: %s mismatch, expected %h, got %h", name, want, got);
    end
  endtask

  // Every strobed result is taken at the edge that ends its cycle and compared with the
  // oldest prediction. A strobe with nothing predicted counts as a mismatch as well.
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("tb: result word with nothing expected, got %p", res_o);
      end else begin
        want = pending_results.pop_front();
        check_field("result_exponents", want.result_exponents, res_o.result_exponents);
        check_field("total_degree", WORD_W'(want.total_degree), WORD_W'(res_o.total_degree));
        check_field("lowest_var", WORD_W'(want.lowest_var), WORD_W'(res_o.lowest_var));
        check_field("highest_var", WORD_W'(want.highest_var), WORD_W'(res_o.highest_var));
        check_field("returned_value", WORD_W'(want.returned_value),
                    WORD_W'(res_o.returned_value));
        check_field("invalid_code", WORD_W'(want.invalid_code), WORD_W'(res_o.invalid_code));
        check_field("overflow", WORD_W'(want.overflow), WORD_W'(res_o.overflow));
      end
    end
  end

  // Watchdog: a hung handshake or a result that never comes ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Build with the largest and smallest exponent, at the lowest and highest variable, with a
  // zero exponent, and with codes on both sides of the valid range. The current monomial is
  // random to show that build ignores it.
  task automatic test_build();
    send_word(make_request(REQ_BUILD, {$urandom, $urandom}, {$urandom, $urandom}, 4'd1, 8'hFF));
    send_word(make_request(REQ_BUILD, {$urandom, $urandom}, {$urandom, $urandom}, 4'd8, 8'h01));
    send_word(make_request(REQ_BUILD, {$urandom, $urandom}, {$urandom, $urandom}, 4'd0, 8'h05));
    send_word(make_request(REQ_BUILD, {$urandom, $urandom}, {$urandom, $urandom}, 4'd15, 8'h00));
    send_word(make_request(REQ_BUILD, {$urandom, $urandom}, {$urandom, $urandom}, 4'd3, 8'h00));
  endtask

  // Every lane saturating, nothing at all, and a mix where some lanes just fit and some do not.
  task automatic test_multiply();
    send_word(make_request(REQ_MULTIPLY, '1, '1, 4'd0, 8'h00));
    send_word(make_request(REQ_MULTIPLY, '0, '0, 4'd5, 8'hFF));
    send_word(make_request(REQ_MULTIPLY, 64'h01FE_7F80_0000_10FF,
                           64'h0001_8080_0000_2001, 4'd9, 8'h5A));
  endtask

  // Incrementing a full lane overflows; an empty top lane becomes one; code 9 is invalid.
  task automatic test_integrate();
    send_word(make_request(REQ_INTEGRATE, 64'h0000_0000_0000_00FF, '0, 4'd1, 8'h00));
    send_word(make_request(REQ_INTEGRATE, 64'h00FF_0000_0000_0000, '1, 4'd8, 8'h00));
    send_word(make_request(REQ_INTEGRATE, {$urandom, $urandom}, '0, 4'd9, 8'h00));
  endtask

  // Differentiating by a variable that is absent wipes the whole monomial; a top lane of one
  // drops to zero; code 0 is invalid.
  task automatic test_differentiate();
    send_word(make_request(REQ_DIFF, 64'h1234_5678_9ABC_DE00, '0, 4'd1, 8'h00));
    send_word(make_request(REQ_DIFF, 64'h01FF_FFFF_FFFF_FFFF, '0, 4'd8, 8'h00));
    send_word(make_request(REQ_DIFF, {$urandom, $urandom}, '0, 4'd0, 8'h00));
  endtask

  task automatic test_substitute();
    send_word(make_request(REQ_SUBST, '1, '0, 4'd1, 8'h00));
    send_word(make_request(REQ_SUBST, {$urandom, $urandom}, '0, 4'd15, 8'h00));
  endtask

  // Request types past substitute must pass the monomial through with all flags low.
  task automatic test_unused_types();
    for (int t = int'(REQ_SUBST) + 1; t < (1 << REQ_W); t++)
      send_word(make_request(REQ_W'(t), '1, '1, 4'd0, 8'hFF));
  endtask

  // Random words, with a long stretch in the middle where the sender never pauses.
  task automatic test_random();
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      gaps_enabled = (n < 150) || (n >= 250);
      send_word(random_request());
    end
    gaps_enabled = 1'b1;
  endtask

  initial begin
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    req_i          = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    gaps_enabled   = 1'b1;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_build();
    test_multiply();
    test_integrate();
    test_differentiate();
    test_substitute();
    test_unused_types();
    test_random();

    // Stop offering words, let the pipeline empty, then watch a little longer for strays.
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (RESULT_LATENCY + 4) @(posedge clk_i);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
